// ===== src/smss_pkg.sv =====
// types and constants for the sorted sparse matrix store
`default_nettype none

package smss_pkg;

   localparam int INDEX_BITS  = 10;
   localparam int KEY_BITS    = 2 * INDEX_BITS;
   localparam int CFG_BITS    = 11;
   localparam int OUT_BITS    = 32;
   localparam int STATUS_BITS = 2;
   localparam int REQ_DATA_BITS = 56;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SCAN_RD  = 8'b0000_0010,
      ST_SCAN_CMP = 8'b0000_0100,
      ST_DECIDE   = 8'b0000_1000,
      ST_SHIFT_RD = 8'b0001_0000,
      ST_SHIFT_WR = 8'b0010_0000,
      ST_INSERT   = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// ===== src/sparse_matrix_sorted_store.sv =====
// Out-of-range requests go straight to the done state; otherwise the scan reads and compares
// slots from 0 until a hit, a larger key or the end (an empty table skips the scan), and an
// insert shifts the entries from slot k upward by one slot before it writes the new entry.
// One beat is in work at a time; the scan uses the key comparator, and the scan and the
// shift share the single read and write port of the entry memory.
// A stalled result holds the next one in the done state; synchronous reset empties the table.
`default_nettype none

module sparse_matrix_sorted_store
   import smss_pkg::*;
#(
   parameter int CAPACITY      = 64,
   parameter int MAX_DIMENSION = 1024,
   parameter int VALUE_BITS    = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   // row, column, write_value
   input  wire  [REQ_DATA_BITS-1:0]  req_tdata,
   // operation
   input  wire  [0:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // read_value
   output logic [OUT_BITS-1:0]       rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]    rsp_tuser,
   input  wire                       csr_wen,
   input  wire  [CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [CFG_BITS-1:0]       csr_wdata
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ENT_BITS = KEY_BITS + VALUE_BITS;
   localparam int DIM_BITS = $clog2(MAX_DIMENSION + 1);
   localparam int LIM_BITS = (DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS;
   localparam logic [LIM_BITS-1:0] MAX_DIM = LIM_BITS'(MAX_DIMENSION);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0]   row_count_ff, row_count_in;
   logic [CFG_BITS-1:0]   column_count_ff, column_count_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   k_ff, k_in;
   logic [CNT_BITS-1:0]   j_ff, j_in;
   logic                  op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] wv_ff, wv_in;
   logic [OUT_BITS-1:0]   res_value_ff, res_value_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic [ENT_BITS-1:0]   mem [CAPACITY];
   logic [ENT_BITS-1:0]   rd_data_ff;
   logic [IDX_BITS-1:0]   mem_raddr;
   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_waddr;
   logic [ENT_BITS-1:0]   mem_wdata;

   logic [LIM_BITS-1:0]   row_lim, col_lim;
   logic                  out_of_range;
   logic [KEY_BITS-1:0]   req_key;
   logic signed [63:0]    wv_ext;
   logic signed [63:0]    stored_ext;
   logic [KEY_BITS-1:0]   ent_key;
   logic                  key_less, key_equal;
   logic                  req_fire, rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign req_key = {req_tdata[INDEX_BITS-1:0], req_tdata[KEY_BITS-1:INDEX_BITS]};
   assign wv_ext  = 64'($signed(req_tdata[KEY_BITS +: OUT_BITS]));

   always_comb begin
      row_lim = (LIM_BITS'(row_count_ff) > MAX_DIM) ? MAX_DIM : LIM_BITS'(row_count_ff);
      col_lim = (LIM_BITS'(column_count_ff) > MAX_DIM) ? MAX_DIM
                                                       : LIM_BITS'(column_count_ff);
      out_of_range = (LIM_BITS'(req_tdata[INDEX_BITS-1:0]) >= row_lim) ||
                     (LIM_BITS'(req_tdata[KEY_BITS-1:INDEX_BITS]) >= col_lim);
   end

   // shared key comparator
   assign ent_key    = rd_data_ff[ENT_BITS-1:VALUE_BITS];
   assign key_less   = ent_key < key_ff;
   assign key_equal  = ent_key == key_ff;
   assign stored_ext = 64'($signed(rd_data_ff[VALUE_BITS-1:0]));

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_ROW_COUNT: begin
               row_count_in = csr_wdata;
            end
            REG_COLUMN_COUNT: begin
               column_count_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      wv_in         = wv_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_raddr     = k_ff[IDX_BITS-1:0];
      mem_we        = 1'b0;
      mem_waddr     = k_ff[IDX_BITS-1:0];
      mem_wdata     = {key_ff, wv_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_tuser[0];
               key_in        = req_key;
               wv_in         = wv_ext[VALUE_BITS-1:0];
               k_in          = '0;
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               if (out_of_range) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_DONE;
               end else if (count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (key_equal) begin
               res_value_in = stored_ext[OUT_BITS-1:0];
               mem_we       = (op_ff == OP_WRITE);
               state_in     = ST_DONE;
            end else if (key_less) begin
               k_in     = k_ff + 1'b1;
               state_in = (k_ff + 1'b1 == count_ff) ? ST_DECIDE : ST_SCAN_RD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            j_in = count_ff;
            if (op_ff == OP_READ) begin
               state_in = ST_DONE;
            end else if (count_ff == FULL_COUNT) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end else if (count_ff == k_ff) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            mem_raddr = IDX_BITS'(j_ff - 1'b1);
            state_in  = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[IDX_BITS-1:0];
            mem_wdata = rd_data_ff;
            j_in      = j_ff - 1'b1;
            state_in  = (j_ff - 1'b1 == k_ff) ? ST_INSERT : ST_SHIFT_RD;
         end
         ST_INSERT: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // entry memory: {row, column, value} per slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         row_count_ff    <= '0;
         column_count_ff <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      j_ff          <= j_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      wv_ff         <= wv_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
      (count_ff == $past(count_ff) + 1'b1))
      else $error("entry count moved by other than one insert");

   a_scan_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_RD) |-> (k_ff < count_ff))
      else $error("scan past the last entry");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL)) |-> (count_ff == FULL_COUNT))
      else $error("table full reported while not full");
`endif

endmodule

`default_nettype wire

// ===== tb/sparse_matrix_sorted_store_test.sv =====
// testbench for the sorted sparse matrix store: directed and random accesses checked per beat
module sparse_matrix_sorted_store_test
   import smss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = 64;
   localparam int MAX_DIMENSION = 1024;

   typedef struct packed {
      logic [OUT_BITS-1:0]    value;
      logic [STATUS_BITS-1:0] status;
   } outcome_type;

   class store_scoreboard;
      int unsigned            row_limit;
      int unsigned            column_limit;
      logic [INDEX_BITS-1:0]  slot_row [CAPACITY];
      logic [INDEX_BITS-1:0]  slot_column [CAPACITY];
      logic [OUT_BITS-1:0]    slot_value [CAPACITY];
      int unsigned            used;
      outcome_type            awaited[$];
      int unsigned            failures;

      function new();
         row_limit = 0;
         column_limit = 0;
         used = 0;
         failures = 0;
      endfunction

      function void set_dimension(logic [CSR_INDEX_BITS-1:0] index,
                                  logic [CFG_BITS-1:0] count);
         int unsigned clamped;
         clamped = (count > MAX_DIMENSION) ? MAX_DIMENSION : count;
         if (index == REG_ROW_COUNT) begin
            row_limit = clamped;
         end else begin
            column_limit = clamped;
         end
      endfunction

      function void note_request(logic op, logic [INDEX_BITS-1:0] r,
                                 logic [INDEX_BITS-1:0] c, logic [OUT_BITS-1:0] v);
         outcome_type result;
         int unsigned k;
         int unsigned j;
         result.value = '0;
         result.status = STATUS_OK;
         if (r >= row_limit || c >= column_limit) begin
            result.status = STATUS_RANGE;
         end else begin
            k = 0;
            while (k < used && {slot_row[k], slot_column[k]} < {r, c}) k++;
            if (k < used && slot_row[k] == r && slot_column[k] == c) begin
               result.value = slot_value[k];
               if (op == OP_WRITE) slot_value[k] = v;
            end else if (op == OP_WRITE) begin
               if (used >= CAPACITY) begin
                  result.status = STATUS_FULL;
               end else begin
                  for (j = used; j > k; j--) begin
                     slot_row[j] = slot_row[j-1];
                     slot_column[j] = slot_column[j-1];
                     slot_value[j] = slot_value[j-1];
                  end
                  slot_row[k] = r;
                  slot_column[k] = c;
                  slot_value[k] = v;
                  used++;
               end
            end
         end
         awaited.push_back(result);
      endfunction

      function void check_response(logic [OUT_BITS-1:0] data, logic [STATUS_BITS-1:0] status);
         outcome_type want;
         if (awaited.size() == 0) begin
            $error("result beat with no request pending: read_value %h status %0d",
                   data, status);
            failures++;
         end else begin
            want = awaited.pop_front();
            if (data !== want.value) begin
               $error("read_value: expected %h, got %h", want.value, data);
               failures++;
            end
            if (status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, status);
               failures++;
            end
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // row, column, write_value
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   // operation
   logic [0:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // read_value
   logic [OUT_BITS-1:0]       rsp_tdata;
   // status
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      csr_wen;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_wdata;

   store_scoreboard           sb;
   logic [KEY_BITS-1:0]       known_keys[$];
   int unsigned               burst_left;

   sparse_matrix_sorted_store uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_beat(input logic op, input logic [INDEX_BITS-1:0] r,
                            input logic [INDEX_BITS-1:0] c, input logic [OUT_BITS-1:0] v);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_BITS'({v, c, r});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, r, c, v);
   endtask

   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_dimensions(input logic [CFG_BITS-1:0] rows,
                                   input logic [CFG_BITS-1:0] columns);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= REG_ROW_COUNT;
      csr_wdata <= rows;
      @(negedge clock);
      csr_index <= REG_COLUMN_COUNT;
      csr_wdata <= columns;
      @(negedge clock);
      csr_wen <= 1'b0;
      sb.set_dimension(REG_ROW_COUNT, rows);
      sb.set_dimension(REG_COLUMN_COUNT, columns);
   endtask

   task automatic run_random(input int unsigned count, input int unsigned row_hi,
                             input int unsigned column_hi, input int unsigned write_pct);
      logic                  op;
      logic [INDEX_BITS-1:0] r;
      logic [INDEX_BITS-1:0] c;
      logic [OUT_BITS-1:0]   v;
      logic [KEY_BITS-1:0]   pick;
      for (int unsigned i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_READ;
         if (known_keys.size() != 0 && $urandom_range(0, 99) < 40) begin
            pick = known_keys[$urandom_range(0, known_keys.size() - 1)];
            r = pick[KEY_BITS-1:INDEX_BITS];
            c = pick[INDEX_BITS-1:0];
         end else begin
            r = INDEX_BITS'($urandom_range(0, row_hi));
            c = INDEX_BITS'($urandom_range(0, column_hi));
         end
         case ($urandom_range(0, 11))
            0:       v = 32'h7fff_ffff;
            1:       v = 32'h8000_0000;
            2:       v = 32'hffff_ffff;
            3:       v = '0;
            default: v = $urandom;
         endcase
         if (op == OP_WRITE) known_keys.push_back({r, c});
         send_beat(op, r, c, v);
      end
   endtask

   initial begin : receiver
      int unsigned seen;
      int unsigned hold;
      int unsigned mode_left;
      int unsigned mode;
      seen = 0;
      hold = 0;
      mode_left = 0;
      mode = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata, rsp_tuser);
            seen++;
            // long hold-off so the block backs up and stalls its input
            if (seen == 120) hold = 400;
         end
      end
   end

   initial begin
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      burst_left = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // zero dimensions: everything out of range
      write_dimensions(11'd0, 11'd0);
      send_beat(OP_READ, 10'd0, 10'd0, 32'd0);
      send_beat(OP_WRITE, 10'd1023, 10'd1023, 32'h0000_1234);
      drain();

      write_dimensions(11'd1024, 11'd1024);
      send_beat(OP_WRITE, 10'd0, 10'd0, 32'h7fff_ffff);
      send_beat(OP_WRITE, 10'd1023, 10'd1023, 32'h8000_0000);
      send_beat(OP_READ, 10'd0, 10'd0, 32'hdead_beef);
      send_beat(OP_READ, 10'd1023, 10'd1023, 32'd0);
      send_beat(OP_READ, 10'd5, 10'd5, 32'd0);
      send_beat(OP_WRITE, 10'd0, 10'd0, 32'd0);
      send_beat(OP_READ, 10'd0, 10'd0, 32'd0);
      send_beat(OP_WRITE, 10'd1023, 10'd0, 32'hffff_ffff);
      send_beat(OP_WRITE, 10'd0, 10'd1023, 32'd1);
      send_beat(OP_WRITE, 10'd512, 10'd512, 32'h5a5a_5a5a);
      send_beat(OP_READ, 10'd0, 10'd1023, 32'd0);
      send_beat(OP_WRITE, 10'd1023, 10'd0, 32'h0000_0010);
      send_beat(OP_READ, 10'd1023, 10'd0, 32'd0);
      drain();

      // row count above the maximum clamps, narrow columns
      write_dimensions(11'd2047, 11'd3);
      send_beat(OP_READ, 10'd1023, 10'd2, 32'd0);
      send_beat(OP_WRITE, 10'd1023, 10'd3, 32'h1111_1111);
      send_beat(OP_WRITE, 10'd1023, 10'd2, 32'hffff_fffb);
      send_beat(OP_READ, 10'd1023, 10'd2, 32'd0);
      send_beat(OP_READ, 10'd0, 10'd0, 32'd0);
      send_beat(OP_WRITE, 10'd600, 10'd1023, 32'h2222_2222);
      drain();

      write_dimensions(11'd1024, 11'd1024);
      run_random(150, 1023, 1023, 50);
      drain();

      write_dimensions(11'd6, 11'd2047);
      run_random(100, 7, 1023, 50);
      drain();

      // small square fills the table
      write_dimensions(11'd9, 11'd9);
      run_random(170, 10, 10, 70);
      drain();

      write_dimensions(11'd1024, 11'd1);
      run_random(60, 1023, 2, 50);
      drain();

      write_dimensions(11'd0, 11'd1024);
      run_random(20, 1023, 1023, 50);
      drain();

      repeat (300) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
